// File: design/gepd_pkg.sv
`timescale 1ns / 1ps

package gepd_pkg;

  localparam int SYMBOL_COUNT = 48;
  localparam int GRAY_BITS    = 6;
  localparam int SAMPLE_W     = 10;
  localparam int OFFSET_W     = 6;
  localparam int POS_W        = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 10;
  localparam int OFFSET_VALS  = 2 ** OFFSET_W;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(512);
  localparam logic [POS_W-1:0]    POS_UNKNOWN     = POS_W'(SYMBOL_COUNT);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_5     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_OFFSET = 3'd6;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_0;
  } gepd_in_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             reading_valid;
    logic             position_accepted;
  } gepd_out_t;

  // offset reduced modulo the symbol count, built at elaboration
  typedef logic [OFFSET_W-1:0] offset_tab_t [OFFSET_VALS];

  function automatic offset_tab_t build_offset_tab();
    offset_tab_t t;
    for (int i = 0; i < OFFSET_VALS; i++) begin
      t[i] = OFFSET_W'(i % SYMBOL_COUNT);
    end
    return t;
  endfunction

  localparam offset_tab_t OFFSET_MOD_TAB = build_offset_tab();

endpackage

// File: design/gepd_lane.sv
`timescale 1ns / 1ps

module gepd_lane
  import gepd_pkg::*;
(
  input  logic                clk_i,
  input  logic                load_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [SAMPLE_W-1:0] threshold_i,
  output logic                bit_o
);

  logic bit_d;
  logic bit_q;

  // dark sample sets the gray bit, equal or brighter clears it
  assign bit_d = (sample_i < threshold_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;

endmodule

// File: design/gepd_merge.sv
`timescale 1ns / 1ps

module gepd_merge
  import gepd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 gray_valid_i,
  input  logic [GRAY_BITS-1:0] gray_i,
  input  logic [OFFSET_W-1:0]  offset_i,
  output logic                 gray_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gepd_out_t            out_data_o
);

  logic [GRAY_BITS-1:0] bin;
  logic                 in_range;
  logic [POS_W-1:0]     cand_raw;
  logic [POS_W-1:0]     cand_sum;
  logic [POS_W-1:0]     cand;
  logic [POS_W-1:0]     cand_next;
  logic                 backspin;
  logic                 accept;
  logic                 take;
  logic                 out_ready;

  logic                 out_valid_q;
  gepd_out_t            out_data_q;
  gepd_out_t            out_data_d;
  logic [POS_W-1:0]     last_pos_q;
  logic [POS_W-1:0]     last_pos_d;

  // gray to binary: each bit is the parity of itself and all bits above
  always_comb begin
    for (int i = 0; i < GRAY_BITS; i++) begin
      bin[i] = ^(gray_i >> i);
    end
  end

  always_comb begin
    in_range  = ({1'b0, bin} < POS_UNKNOWN);
    cand_raw  = POS_W'(SYMBOL_COUNT - 1) - {1'b0, bin};
    cand_sum  = POS_W'(cand_raw[OFFSET_W-1:0]) + POS_W'(offset_i);
    cand      = (cand_sum >= POS_UNKNOWN) ? cand_sum - POS_UNKNOWN : cand_sum;
    cand_next = cand + POS_W'(1);
    if (cand_next == POS_UNKNOWN) begin
      cand_next = '0;
    end
    backspin  = (cand_next == last_pos_q);
    accept    = in_range && !backspin;
  end

  assign out_ready    = !out_valid_q || !out_stall_i;
  assign take         = gray_valid_i && out_ready;
  assign gray_ready_o = out_ready;

  always_comb begin
    last_pos_d                   = accept ? cand : last_pos_q;
    out_data_d.position          = last_pos_d;
    out_data_d.reading_valid     = in_range;
    out_data_d.position_accepted = accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_pos_q  <= POS_UNKNOWN;
    end else if (take) begin
      out_valid_q <= 1'b1;
      last_pos_q  <= last_pos_d;
    end else if (out_ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: design/gray_encoder_position_decoder.sv
`timescale 1ns / 1ps

// absolute position decoder for a 6-bit gray-coded encoder wheel
// input channel: in_valid_i / in_stall_o / in_data_i, one transaction holds
//   six reflectance samples, one per gray bit, in sensor order
// output channel: out_valid_o / out_stall_i / out_data_o, exactly one
//   transaction per input: accepted position, reading valid, accepted flag
// config channel: cfg_valid_i / cfg_ready_o with cfg_index_i, cfg_data_i;
//   indexes 0..5 are the per-bit thresholds, 6 the position offset, 7 is
//   ignored; ready is always high, write only while the block is idle
// pipeline: out_valid_o rises once an accepted input has passed the lane
//   compare register, then the merge and output register
// throughput: one transaction per cycle unless the output stalls; the only
//   loop is the single last-position register, updated in the merge stage
// reset: thresholds go to 512, offset to 0, position to the symbol count
//   (unknown) and both pipeline stages empty
// stall: a stalled output holds its data; the compare stage keeps taking
//   one more transaction, then in_stall_o rises until the output drains

module gray_encoder_position_decoder
  import gepd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  gepd_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gepd_out_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [SAMPLE_W-1:0]  threshold_q [GRAY_BITS];
  logic [OFFSET_W-1:0]  offset_q;
  logic [SAMPLE_W-1:0]  samples     [GRAY_BITS];
  logic [GRAY_BITS-1:0] gray;
  logic                 cfg_we;
  logic                 s1_valid_q;
  logic                 s1_ready;
  logic                 s1_advance;
  logic                 in_take;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GRAY_BITS; i++) begin
        threshold_q[i] <= THRESHOLD_RESET;
      end
      offset_q <= '0;
    end else if (cfg_we) begin
      for (int i = 0; i < GRAY_BITS; i++) begin
        if (cfg_index_i == REG_THRESHOLD_0 + CFG_IDX_W'(i)) begin
          threshold_q[i] <= cfg_data_i[SAMPLE_W-1:0];
        end
      end
      // offset is stored already reduced modulo the symbol count
      if (cfg_index_i == REG_POSITION_OFFSET) begin
        offset_q <= OFFSET_MOD_TAB[cfg_data_i[OFFSET_W-1:0]];
      end
    end
  end

  // unpack the samples into lane order
  assign samples[0] = in_data_i.sample_0;
  assign samples[1] = in_data_i.sample_1;
  assign samples[2] = in_data_i.sample_2;
  assign samples[3] = in_data_i.sample_3;
  assign samples[4] = in_data_i.sample_4;
  assign samples[5] = in_data_i.sample_5;

  // stage 1 moves when empty or when the merge stage takes its transaction
  assign s1_advance = !s1_valid_q || s1_ready;
  assign in_stall_o = !s1_advance;
  assign in_take    = in_valid_i && s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // one threshold compare lane per gray bit
  for (genvar g = 0; g < GRAY_BITS; g++) begin : g_lane
    gepd_lane u_lane (
      .clk_i       (clk_i),
      .load_i      (in_take),
      .sample_i    (samples[g]),
      .threshold_i (threshold_q[g]),
      .bit_o       (gray[g])
    );
  end

  // lanes merge into the gray word, decoded against the last position
  gepd_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gray_valid_i (s1_valid_q),
    .gray_i       (gray),
    .offset_i     (offset_q),
    .gray_ready_o (s1_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// File: bench/tb_gray_encoder_position_decoder.sv
`timescale 1ns / 1ps

module tb_gray_encoder_position_decoder;
  import gepd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_SETTING = 290;
  localparam int NUM_SETTINGS = 6;
  localparam int NUM_DIRECTED = 20;
  localparam int DRAIN_CYCLES = 4;
  // index past the last register, the block must drop writes to it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_POSITION_OFFSET + 3'd1;

  // one row of the directed table; expected result is only used when typed is set
  typedef struct {
    gepd_in_t  item;
    bit        typed;
    gepd_out_t result;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  gepd_in_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  gepd_out_t             out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // shadow copy of the wheel decoder state and registers
  int wheel_pos;
  int wheel_offset;
  int dark_limit [GRAY_BITS];

  gepd_out_t pending_readings [$];
  gepd_out_t want;
  dir_row_t  dir_table [NUM_DIRECTED];

  int errors;
  int cycle_count;
  int in_idle_pct;
  int out_stall_pct;

  gray_encoder_position_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // runaway guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // predicted result of one snapshot; advances the shadow position
  function automatic gepd_out_t decode_reading(input gepd_in_t snap);
    logic [GRAY_BITS*SAMPLE_W-1:0] flat;
    logic [GRAY_BITS-1:0]          code;
    logic [GRAY_BITS-1:0]          bin;
    int                            cand;
    gepd_out_t                     res;
    flat = snap;
    for (int i = 0; i < GRAY_BITS; i++) begin
      // strictly below the limit reads as a dark stripe
      code[i] = (int'(flat[i*SAMPLE_W +: SAMPLE_W]) < dark_limit[i]);
    end
    // gray to binary, msb passes through
    bin[GRAY_BITS-1] = code[GRAY_BITS-1];
    for (int i = GRAY_BITS - 2; i >= 0; i--) begin
      bin[i] = bin[i+1] ^ code[i];
    end
    res.reading_valid     = 1'b0;
    res.position_accepted = 1'b0;
    if (int'(bin) < SYMBOL_COUNT) begin
      res.reading_valid = 1'b1;
      cand = (SYMBOL_COUNT - 1 - int'(bin) + wheel_offset) % SYMBOL_COUNT;
      // one step behind the last position is backspin and is dropped
      if ((cand + 1) % SYMBOL_COUNT != wheel_pos) begin
        wheel_pos = cand;
        res.position_accepted = 1'b1;
      end
    end
    res.position = POS_W'(wheel_pos);
    return res;
  endfunction

  // snapshot whose set bits are dark (below) and clear bits light (above)
  function automatic dir_row_t row(input logic [GRAY_BITS-1:0] code,
                                   input int below, input int above, input bit typed,
                                   input int pos, input bit rv, input bit acc);
    logic [GRAY_BITS*SAMPLE_W-1:0] flat;
    dir_row_t                      r;
    for (int i = 0; i < GRAY_BITS; i++) begin
      flat[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(code[i] ? below : above);
    end
    r.item                     = gepd_in_t'(flat);
    r.typed                    = typed;
    r.result.position          = POS_W'(pos);
    r.result.reading_valid     = rv;
    r.result.position_accepted = acc;
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input bit dark, input int limit);
    if (dark) begin
      // a zero limit can never read dark
      if (limit == 0) return SAMPLE_W'($urandom_range(1023));
      if ($urandom_range(3) == 0) return SAMPLE_W'(limit - 1);
      return SAMPLE_W'($urandom_range(limit - 1));
    end
    if ($urandom_range(3) == 0) return SAMPLE_W'(limit);
    return SAMPLE_W'($urandom_range(1023, limit));
  endfunction

  // mostly plausible wheel motion around the current position, some
  // out-of-range codes and some plain noise
  function automatic gepd_in_t wheel_snapshot();
    logic [GRAY_BITS*SAMPLE_W-1:0] flat;
    logic [GRAY_BITS-1:0]          bin;
    logic [GRAY_BITS-1:0]          code;
    int                            pick;
    int                            target;
    int                            raw;
    pick = $urandom_range(99);
    if (pick < 10) begin
      for (int i = 0; i < GRAY_BITS; i++) begin
        flat[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(1023));
      end
      return gepd_in_t'(flat);
    end
    if (pick < 20) begin
      bin = GRAY_BITS'($urandom_range(63, SYMBOL_COUNT));
    end else begin
      if (wheel_pos == SYMBOL_COUNT) begin
        target = $urandom_range(SYMBOL_COUNT - 1);
      end else begin
        case ($urandom_range(9))
          0, 1:    target = wheel_pos;
          2, 3, 4: target = (wheel_pos + 1) % SYMBOL_COUNT;
          5, 6:    target = (wheel_pos + SYMBOL_COUNT - 1) % SYMBOL_COUNT;
          7:       target = (wheel_pos + 2) % SYMBOL_COUNT;
          default: target = $urandom_range(SYMBOL_COUNT - 1);
        endcase
      end
      // undo offset and direction reversal to find the wheel code
      raw = (target - wheel_offset % SYMBOL_COUNT + SYMBOL_COUNT) % SYMBOL_COUNT;
      bin = GRAY_BITS'(SYMBOL_COUNT - 1 - raw);
    end
    code = bin ^ (bin >> 1);
    for (int i = 0; i < GRAY_BITS; i++) begin
      flat[i*SAMPLE_W +: SAMPLE_W] = pick_sample(code[i], dark_limit[i]);
    end
    return gepd_in_t'(flat);
  endfunction

  // one input transaction with a random lead-in gap
  task automatic send_item(input gepd_in_t item, input bit typed, input gepd_out_t result);
    gepd_out_t got;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    got = decode_reading(item);
    pending_readings.push_back(typed ? result : got);
  endtask

  // caller lowers cfg_valid_i after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_POSITION_OFFSET) begin
      wheel_offset = int'(val[OFFSET_W-1:0]);
    end else if (idx <= REG_THRESHOLD_5) begin
      dark_limit[idx] = int'(val);
    end
  endtask

  task automatic load_setting(input int n);
    logic [CFG_DATA_W-1:0] limits [GRAY_BITS];
    logic [OFFSET_W-1:0]   off;
    for (int i = 0; i < GRAY_BITS; i++) begin
      case (n)
        1:       limits[i] = (i % 2 != 0) ? 10'd1023 : 10'd0;
        2:       limits[i] = 10'd1023;
        3:       limits[i] = 10'd1;
        default: limits[i] = CFG_DATA_W'($urandom_range(1023));
      endcase
    end
    case (n)
      0:       off = 6'd63;
      1:       off = 6'd47;
      2:       off = 6'd48;
      3:       off = 6'd0;
      default: off = OFFSET_W'($urandom_range(63));
    endcase
    for (int i = 0; i < GRAY_BITS; i++) begin
      write_reg(CFG_IDX_W'(REG_THRESHOLD_0 + i), limits[i]);
    end
    // upper data bits are junk, only the low six bits count
    write_reg(REG_POSITION_OFFSET, {4'($urandom), off});
    if (n == 3) begin
      write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // output side: compare each transaction, then pick the next stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_readings.size() == 0) begin
          $error("unexpected output transaction: position %0d", out_data_o.position);
          errors++;
        end else begin
          want = pending_readings.pop_front();
          if (out_data_o.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_data_o.position);
            errors++;
          end
          if (out_data_o.reading_valid !== want.reading_valid) begin
            $error("reading_valid: expected %0b, got %0b",
                   want.reading_valid, out_data_o.reading_valid);
            errors++;
          end
          if (out_data_o.position_accepted !== want.position_accepted) begin
            $error("position_accepted: expected %0b, got %0b",
                   want.position_accepted, out_data_o.position_accepted);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < out_stall_pct);
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    errors        = 0;
    cycle_count   = 0;
    in_idle_pct   = 16;
    out_stall_pct = 65;
    wheel_pos     = SYMBOL_COUNT;
    wheel_offset  = 0;
    for (int i = 0; i < GRAY_BITS; i++) dark_limit[i] = int'(THRESHOLD_RESET);

    // directed rows under reset thresholds (512) and zero offset
    dir_table = '{
      // out of range before any position is known
      row(6'h28, 0, 1023, 1, SYMBOL_COUNT, 0, 0),
      row(6'h20, 0, 1023, 1, SYMBOL_COUNT, 0, 0),
      // all light: first valid reading is taken
      row(6'h00, 0, 1023, 1, 47, 1, 1),
      // sample equal to the limit reads light, same position again
      row(6'h00, 0, 512, 1, 47, 1, 1),
      // one step behind: backspin
      row(6'h01, 0, 1023, 1, 47, 1, 0),
      row(6'h3F, 511, 512, 0, 0, 0, 0),
      row(6'h38, 0, 1023, 1, 0, 1, 1),
      // backspin across the wrap from 0 to 47
      row(6'h00, 0, 1023, 1, 0, 1, 0),
      row(6'h38, 511, 1023, 1, 0, 1, 1),
      row(6'h02, 0, 1023, 0, 0, 0, 0),
      row(6'h04, 0, 1023, 0, 0, 0, 0),
      row(6'h08, 0, 1023, 0, 0, 0, 0),
      row(6'h10, 0, 1023, 0, 0, 0, 0),
      row(6'h03, 0, 1023, 0, 0, 0, 0),
      row(6'h15, 511, 513, 0, 0, 0, 0),
      row(6'h2A, 0, 1023, 0, 0, 0, 0),
      row(6'h30, 0, 1023, 0, 0, 0, 0),
      row(6'h29, 0, 1023, 0, 0, 0, 0),
      row(6'h3C, 0, 1023, 0, 0, 0, 0),
      row(6'h1F, 0, 1023, 0, 0, 0, 0)
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_item(dir_table[r].item, dir_table[r].typed, dir_table[r].result);
    end
    in_valid_i <= 1'b0;
    wait_idle();

    // two register settings per idling mode: sender light / receiver heavy,
    // then the reverse, then free running
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s / 2)
        0: begin
          in_idle_pct   = 16;
          out_stall_pct = 65;
        end
        1: begin
          in_idle_pct   = 65;
          out_stall_pct = 16;
        end
        default: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
      endcase
      load_setting(s);
      repeat (ITEMS_PER_SETTING) send_item(wheel_snapshot(), 1'b0, '0);
      in_valid_i <= 1'b0;
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
